### rtl/core/slcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcp_pkg
// Shared constants, types and helpers for the status line command parser.
// ----------------------------------------------------------------------------
package slcp_pkg;

    // line geometry
    localparam int LINE_SIZE  = 16;
    localparam int LINE_DEPTH = LINE_SIZE - 1;
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

    // characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_W     = 8'h57;

    // command layout
    localparam int CMD_MIN_LEN  = 4;
    localparam int TIME_LEN     = 7;
    localparam int POS_CMD0     = 0;
    localparam int POS_CMD1     = 1;
    localparam int POS_SEP      = 2;
    localparam int POS_HOUR_HI  = 3;
    localparam int POS_HOUR_LO  = 4;
    localparam int POS_MIN_HI   = 5;
    localparam int POS_MIN_LO   = 6;

    // value limits and codes
    localparam logic [16:0] NUM_CAP       = 17'd65536;
    localparam logic [16:0] COST_MAX      = 17'd65535;
    localparam logic [16:0] PCT_MAX       = 17'd100;
    localparam logic [16:0] COST_UNKNOWN  = 17'h1FFFF;
    localparam logic [15:0] COST_CLAMP    = 16'd65534;
    localparam logic [15:0] COST_UNK_CODE = 16'hFFFF;
    localparam logic [7:0]  BYTE_UNKNOWN  = 8'hFF;
    localparam logic signed [12:0] HOUR_MAX = 13'sd23;
    localparam logic signed [12:0] MIN_MAX  = 13'sd59;

    // line buffer control from the top level
    typedef struct packed {
        logic             push;
        logic             clear;
        logic [7:0]       wr_byte;
        logic [IDX_W-1:0] rd_addr;
    } t_lb_ctrl;

    // one result transaction
    typedef struct packed {
        logic [31:0] usage_word;
        logic [31:0] cost_pair_word;
        logic [15:0] cost_last;
        logic        cost_present;
    } t_result;

    function automatic logic f_is_digit(input logic [7:0] c);
        f_is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic f_is_space(input logic [7:0] c);
        f_is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [15:0] f_cost_code(input logic [16:0] v);
        if (v == COST_UNKNOWN) begin
            f_cost_code = COST_UNK_CODE;
        end else if (v[15:0] == COST_UNK_CODE) begin
            f_cost_code = COST_CLAMP;
        end else begin
            f_cost_code = v[15:0];
        end
    endfunction

endpackage

### rtl/core/slcp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcp_if
// Valid/ready channels: received characters in, status results out.
// ----------------------------------------------------------------------------
interface slcp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcp_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] usage_word;
    logic [31:0] cost_pair_word;
    logic [15:0] cost_last;
    logic        cost_present;

    modport source (output valid, output usage_word, output cost_pair_word,
                    output cost_last, output cost_present, input ready);
    modport sink   (input valid, input usage_word, input cost_pair_word,
                    input cost_last, input cost_present, output ready);
endinterface

### rtl/core/slcp_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcp_line_buf
// Line store memory with fill count: appends characters, drops an
// overlong line, and serves one registered read per cycle for the parser.
// ----------------------------------------------------------------------------
module slcp_line_buf (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  slcp_pkg::t_lb_ctrl     i_ctrl,
    output logic [slcp_pkg::CNT_W-1:0] o_count,
    output logic [7:0]             o_rd_data
);

    logic [7:0]                 r_mem [slcp_pkg::LINE_DEPTH];
    logic [slcp_pkg::CNT_W-1:0] r_count;
    logic [slcp_pkg::CNT_W-1:0] n_count;
    logic [7:0]                 r_rd_data;
    logic                       w_room;

    assign w_room = (r_count < slcp_pkg::CNT_W'(slcp_pkg::LINE_DEPTH));

    // fill count: append, overflow drop or line end
    always_comb begin
        n_count = r_count;
        if (i_ctrl.clear) begin
            n_count = '0;
        end else if (i_ctrl.push) begin
            if (w_room) begin
                n_count = r_count + 1'b1;
            end else begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && w_room) begin
            r_mem[r_count[slcp_pkg::IDX_W-1:0]] <= i_ctrl.wr_byte;
        end
    end

    // memory read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_ctrl.rd_addr];
    end

    assign o_count   = r_count;
    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/slcp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcp_parse
// Scans a finished line out of the line store one character per cycle,
// decodes the command, number and time digits, and updates the status.
// ----------------------------------------------------------------------------
module slcp_parse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [slcp_pkg::CNT_W-1:0]  i_len,
    input  logic [7:0]                  i_rd_data,
    input  logic                        i_out_free,
    output logic [slcp_pkg::IDX_W-1:0]  o_rd_addr,
    output logic                        o_idle,
    output logic                        o_emit,
    output slcp_pkg::t_result           o_result
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef enum logic [2:0] {
        NP_WS  = 3'b001,
        NP_DIG = 3'b010,
        NP_END = 3'b100
    } t_num_ph;

    t_state                     r_state, n_state;
    logic [slcp_pkg::CNT_W-1:0] r_len, n_len;
    logic [slcp_pkg::CNT_W-1:0] r_addr, n_addr;
    logic [slcp_pkg::CNT_W-1:0] r_didx, n_didx;
    logic                       r_dv, n_dv;
    logic [7:0]                 r_c0, n_c0;
    logic [7:0]                 r_c1, n_c1;
    logic                       r_colon, n_colon;
    t_num_ph                    r_nph, n_nph;
    logic                       r_neg, n_neg;
    logic [16:0]                r_mag, n_mag;
    logic signed [12:0]         r_hh, n_hh;
    logic signed [12:0]         r_mm, n_mm;
    logic [7:0]                 r_five, n_five;
    logic [7:0]                 r_week, n_week;
    logic [7:0]                 r_hour, n_hour;
    logic [7:0]                 r_min, n_min;
    logic [16:0]                r_cost0, n_cost0;
    logic [16:0]                r_cost1, n_cost1;
    logic [16:0]                r_cost2, n_cost2;

    logic [7:0]         w_d;
    logic               w_digit;
    logic [20:0]        w_mag_x10;
    logic signed [12:0] w_dig_s;
    logic signed [12:0] w_dig_x10;
    logic               w_num_ok;
    logic               w_is_d;
    logic               w_is_c;
    logic               w_upd_cost;
    logic               w_upd_pct;
    logic               w_upd_time;
    logic               w_upd;
    logic               w_last;

    // character datapath
    assign w_d       = i_rd_data;
    assign w_digit   = slcp_pkg::f_is_digit(w_d);
    assign w_mag_x10 = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                     + {17'd0, w_d[3:0]};
    assign w_dig_s   = $signed({5'd0, w_d}) - 13'sd48;
    assign w_dig_x10 = (w_dig_s <<< 3) + (w_dig_s <<< 1);
    assign w_last    = (r_didx == (r_len - 1'b1));

    // command decode at line end
    assign w_num_ok   = !(r_neg && (r_mag != '0));
    assign w_is_d     = r_colon && (r_c0 == slcp_pkg::CH_D);
    assign w_is_c     = r_colon && (r_c0 == slcp_pkg::CH_C);
    assign w_upd_cost = w_is_d && w_num_ok && (r_mag <= slcp_pkg::COST_MAX)
                     && ((r_c1 == slcp_pkg::CH_O) || (r_c1 == slcp_pkg::CH_S)
                         || (r_c1 == slcp_pkg::CH_F));
    assign w_upd_pct  = w_is_c && w_num_ok && (r_mag <= slcp_pkg::PCT_MAX)
                     && ((r_c1 == slcp_pkg::CH_U) || (r_c1 == slcp_pkg::CH_W));
    assign w_upd_time = w_is_c && (r_c1 == slcp_pkg::CH_R)
                     && (r_len == slcp_pkg::CNT_W'(slcp_pkg::TIME_LEN))
                     && (r_hh >= 13'sd0) && (r_hh <= slcp_pkg::HOUR_MAX)
                     && (r_mm >= 13'sd0) && (r_mm <= slcp_pkg::MIN_MAX);
    assign w_upd      = w_upd_cost || w_upd_pct || w_upd_time;

    // sequencer and scan
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_addr  = r_addr;
        n_didx  = r_didx;
        n_dv    = 1'b0;
        n_c0    = r_c0;
        n_c1    = r_c1;
        n_colon = r_colon;
        n_nph   = r_nph;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_hh    = r_hh;
        n_mm    = r_mm;
        n_five  = r_five;
        n_week  = r_week;
        n_hour  = r_hour;
        n_min   = r_min;
        n_cost0 = r_cost0;
        n_cost1 = r_cost1;
        n_cost2 = r_cost2;
        o_emit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_len   = i_len;
                    n_addr  = '0;
                    n_colon = 1'b0;
                    n_nph   = NP_WS;
                    n_neg   = 1'b0;
                    n_mag   = '0;
                    // too short for any command: drop without a scan
                    if (i_len >= slcp_pkg::CNT_W'(slcp_pkg::CMD_MIN_LEN)) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue the next read
                if (r_addr != r_len) begin
                    n_dv   = 1'b1;
                    n_didx = r_addr;
                    n_addr = r_addr + 1'b1;
                end
                // evaluate the character read last cycle
                if (r_dv) begin
                    if (r_didx == slcp_pkg::CNT_W'(slcp_pkg::POS_CMD0)) begin
                        n_c0 = w_d;
                    end
                    if (r_didx == slcp_pkg::CNT_W'(slcp_pkg::POS_CMD1)) begin
                        n_c1 = w_d;
                    end
                    if (r_didx == slcp_pkg::CNT_W'(slcp_pkg::POS_SEP)) begin
                        n_colon = (w_d == slcp_pkg::CH_COLON);
                    end
                    if (r_didx == slcp_pkg::CNT_W'(slcp_pkg::POS_HOUR_HI)) begin
                        n_hh = w_dig_x10;
                    end
                    if (r_didx == slcp_pkg::CNT_W'(slcp_pkg::POS_HOUR_LO)) begin
                        n_hh = r_hh + w_dig_s;
                    end
                    if (r_didx == slcp_pkg::CNT_W'(slcp_pkg::POS_MIN_HI)) begin
                        n_mm = w_dig_x10;
                    end
                    if (r_didx == slcp_pkg::CNT_W'(slcp_pkg::POS_MIN_LO)) begin
                        n_mm = r_mm + w_dig_s;
                    end
                    // number text: blanks, optional sign, digits
                    if (r_didx >= slcp_pkg::CNT_W'(slcp_pkg::POS_HOUR_HI)) begin
                        unique case (r_nph)
                            NP_WS: begin
                                if (slcp_pkg::f_is_space(w_d)) begin
                                    n_nph = NP_WS;
                                end else if ((w_d == slcp_pkg::CH_PLUS)
                                             || (w_d == slcp_pkg::CH_MINUS)) begin
                                    n_neg = (w_d == slcp_pkg::CH_MINUS);
                                    n_nph = NP_DIG;
                                end else if (w_digit) begin
                                    n_mag = {13'd0, w_d[3:0]};
                                    n_nph = NP_DIG;
                                end else begin
                                    n_nph = NP_END;
                                end
                            end
                            NP_DIG: begin
                                if (w_digit) begin
                                    if (w_mag_x10 > {4'd0, slcp_pkg::NUM_CAP}) begin
                                        n_mag = slcp_pkg::NUM_CAP;
                                    end else begin
                                        n_mag = w_mag_x10[16:0];
                                    end
                                end else begin
                                    n_nph = NP_END;
                                end
                            end
                            NP_END: begin
                                n_nph = NP_END;
                            end
                            default: begin
                                n_nph = NP_END;
                            end
                        endcase
                    end
                    if (w_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!w_upd) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                    if (w_upd_cost) begin
                        if (r_c1 == slcp_pkg::CH_O) begin
                            n_cost0 = r_mag;
                        end else if (r_c1 == slcp_pkg::CH_S) begin
                            n_cost1 = r_mag;
                        end else begin
                            n_cost2 = r_mag;
                        end
                    end
                    if (w_upd_pct) begin
                        if (r_c1 == slcp_pkg::CH_U) begin
                            n_five = r_mag[7:0];
                        end else begin
                            n_week = r_mag[7:0];
                        end
                    end
                    if (w_upd_time) begin
                        n_hour = r_hh[7:0];
                        n_min  = r_mm[7:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result built from the updated status
    always_comb begin
        o_result.usage_word = {n_five, n_week, n_hour, n_min};
        o_result.cost_present = (n_cost0 != slcp_pkg::COST_UNKNOWN)
                             || (n_cost1 != slcp_pkg::COST_UNKNOWN)
                             || (n_cost2 != slcp_pkg::COST_UNKNOWN);
        if (o_result.cost_present) begin
            o_result.cost_pair_word = {slcp_pkg::f_cost_code(n_cost0),
                                       slcp_pkg::f_cost_code(n_cost1)};
            o_result.cost_last      = slcp_pkg::f_cost_code(n_cost2);
        end else begin
            o_result.cost_pair_word = '0;
            o_result.cost_last      = '0;
        end
    end

    // control and status registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
            r_five  <= slcp_pkg::BYTE_UNKNOWN;
            r_week  <= slcp_pkg::BYTE_UNKNOWN;
            r_hour  <= slcp_pkg::BYTE_UNKNOWN;
            r_min   <= slcp_pkg::BYTE_UNKNOWN;
            r_cost0 <= slcp_pkg::COST_UNKNOWN;
            r_cost1 <= slcp_pkg::COST_UNKNOWN;
            r_cost2 <= slcp_pkg::COST_UNKNOWN;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            r_five  <= n_five;
            r_week  <= n_week;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_cost0 <= n_cost0;
            r_cost1 <= n_cost1;
            r_cost2 <= n_cost2;
        end
    end

    // scan datapath registers
    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_addr  <= n_addr;
        r_didx  <= n_didx;
        r_c0    <= n_c0;
        r_c1    <= n_c1;
        r_colon <= n_colon;
        r_nph   <= n_nph;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_hh    <= n_hh;
        r_mm    <= n_mm;
    end

    assign o_rd_addr = r_addr[slcp_pkg::IDX_W-1:0];
    assign o_idle    = (r_state == S_IDLE);

    // a result is only produced when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_out_free)
        else $error("result produced while output register is occupied");

    // the read pointer never runs past the captured line length
    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_len))
        else $error("scan read pointer beyond line length");

    // read data is only evaluated while scanning
    a_dv_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == S_SCAN))
        else $error("memory read data pending outside the scan");

    // a pending decision with a free output always completes next cycle
    a_done_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && i_out_free) |=> (r_state == S_IDLE))
        else $error("decision stalled with a free output register");

endmodule

### rtl/core/status_line_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_line_command_parser
// Collects received characters into lines and turns status commands into
// packed usage and cost transactions.
// ----------------------------------------------------------------------------
//  port     dir  payload                                          handshake
//  i_rx     in   rx_byte[7:0]                                      valid/ready
//  o_res    out  usage_word[31:0] cost_pair_word[31:0]             valid/ready
//                cost_last[15:0] cost_present
//
//  An ordinary character is written to the line store when accepted.
//  A line end of length n (4 or more) holds i_rx.ready low through the scan
//  and decision: the line store has one read port, so the scan reads one
//  character a cycle through its registered read, then decides the command.
//  Synchronous active-low reset; the line store needs no clearing pass.
//  A stalled o_res holds its transaction; the parser waits in its decision
//  state only when a new result is due and the output register is full.
// ----------------------------------------------------------------------------
module status_line_command_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slcp_rx_if.sink      i_rx,
    slcp_res_if.source   o_res
);

    slcp_pkg::t_lb_ctrl         w_lb_ctrl;
    slcp_pkg::t_result          w_result;
    slcp_pkg::t_result          r_res;
    logic [slcp_pkg::CNT_W-1:0] w_count;
    logic [7:0]                 w_rd_data;
    logic [slcp_pkg::IDX_W-1:0] w_rd_addr;
    logic                       w_idle;
    logic                       w_emit;
    logic                       w_accept;
    logic                       w_eol;
    logic                       w_start;
    logic                       w_out_free;
    logic                       r_res_vld;

    // input transaction decode
    assign i_rx.ready = w_idle;
    assign w_accept   = i_rx.valid && w_idle;
    assign w_eol      = (i_rx.rx_byte == slcp_pkg::CH_CR)
                     || (i_rx.rx_byte == slcp_pkg::CH_LF);
    assign w_start    = w_accept && w_eol && (w_count != '0);

    assign w_lb_ctrl.push    = w_accept && !w_eol;
    assign w_lb_ctrl.clear   = w_accept && w_eol;
    assign w_lb_ctrl.wr_byte = i_rx.rx_byte;
    assign w_lb_ctrl.rd_addr = w_rd_addr;

    slcp_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_lb_ctrl),
        .o_count   (w_count),
        .o_rd_data (w_rd_data)
    );

    slcp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_len      (w_count),
        .i_rd_data  (w_rd_data),
        .i_out_free (w_out_free),
        .o_rd_addr  (w_rd_addr),
        .o_idle     (w_idle),
        .o_emit     (w_emit),
        .o_result   (w_result)
    );

    // output register
    assign w_out_free = !r_res_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (w_emit) begin
            r_res_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_res <= w_result;
        end
    end

    assign o_res.valid          = r_res_vld;
    assign o_res.usage_word     = r_res.usage_word;
    assign o_res.cost_pair_word = r_res.cost_pair_word;
    assign o_res.cost_last      = r_res.cost_last;
    assign o_res.cost_present   = r_res.cost_present;

endmodule
